// ===== sv/sca_pkg.sv =====
// Shared types and constants for the sparse COO assembly table.
// Used by every module of the block except sca_ram; depends on nothing.
`default_nettype none

package sca_pkg;

  localparam int DEF_CAPACITY   = 1024;
  localparam int DEF_INDEX_BITS = 16;
  localparam int DEF_VALUE_BITS = 32;

  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET   = 2'd0,
    MODE_GET   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED   = 3'd0,
    ST_APPENDED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_DONE      = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALLOW_DUP   = 2'd0,
    CFG_OVR_APPENDS = 2'd1,
    CFG_ONE_BASED   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_APPEND,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_item;
    logic    scan_start;
    logic    scan_step;
    logic    append;
    logic    clear;
    logic    code_we;
    status_t code;
    logic    out_load;
  } sca_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  bad;
    logic  need_search;
    logic  empty;
    logic  full;
    logic  scan_done;
    logic  found_any;
    logic  out_busy;
  } sca_stat_t;

endpackage

`default_nettype wire

// ===== sv/sca_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
`default_nettype none

module sca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sca_ctrl.sv =====
// Controller state machine for the sparse COO assembly table.
// Depends on sca_pkg for the state, command and status types.
`default_nettype none

module sca_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sca_pkg::sca_stat_t   stat,
  output sca_pkg::sca_cmd_t         cmd
);

  sca_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sca_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sca_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = sca_pkg::S_DECODE;
        end
      end
      sca_pkg::S_DECODE: begin
        unique case (stat.mode)
          sca_pkg::MODE_GET: begin
            if (stat.bad || stat.empty) begin
              state_nxt = sca_pkg::S_DONE;
            end else begin
              state_nxt = sca_pkg::S_SCAN;
            end
          end
          sca_pkg::MODE_SET: begin
            if (stat.bad) begin
              state_nxt = sca_pkg::S_DONE;
            end else if (stat.need_search && !stat.empty) begin
              state_nxt = sca_pkg::S_SCAN;
            end else begin
              state_nxt = sca_pkg::S_APPEND;
            end
          end
          default: state_nxt = sca_pkg::S_DONE;
        endcase
      end
      sca_pkg::S_SCAN: begin
        if (stat.scan_done) begin
          if (stat.mode == sca_pkg::MODE_SET && !stat.found_any) begin
            state_nxt = sca_pkg::S_APPEND;
          end else begin
            state_nxt = sca_pkg::S_DONE;
          end
        end
      end
      sca_pkg::S_APPEND: state_nxt = sca_pkg::S_DONE;
      sca_pkg::S_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = sca_pkg::S_IDLE;
        end
      end
      default: state_nxt = sca_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    cmd.code = sca_pkg::ST_DONE;
    in_ready = 1'b0;
    unique case (state_r)
      sca_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      sca_pkg::S_DECODE: begin
        cmd.code_we = 1'b1;
        unique case (stat.mode)
          sca_pkg::MODE_CLEAR: cmd.clear = 1'b1;
          sca_pkg::MODE_GET: begin
            if (stat.bad) begin
              cmd.code = sca_pkg::ST_BAD_INDEX;
            end else if (!stat.empty) begin
              cmd.scan_start = 1'b1;
            end
          end
          sca_pkg::MODE_SET: begin
            if (stat.bad) begin
              cmd.code = sca_pkg::ST_BAD_INDEX;
            end else if (stat.need_search && !stat.empty) begin
              cmd.scan_start = 1'b1;
            end
          end
          default: cmd.code = sca_pkg::ST_DONE;
        endcase
      end
      sca_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done && stat.mode == sca_pkg::MODE_SET && stat.found_any) begin
          cmd.code_we = 1'b1;
          cmd.code    = sca_pkg::ST_UPDATED;
        end else if (stat.scan_done && stat.mode == sca_pkg::MODE_GET) begin
          cmd.code_we = 1'b1;
        end
      end
      sca_pkg::S_APPEND: begin
        cmd.code_we = 1'b1;
        cmd.append  = !stat.full;
        cmd.code    = stat.full ? sca_pkg::ST_FULL : sca_pkg::ST_APPENDED;
      end
      sca_pkg::S_DONE: cmd.out_load = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/sca_dpath.sv =====
// Datapath of the sparse COO assembly table: item registers, entry store,
// scan counters, accumulator, config registers and result register.
// Depends on sca_pkg and sca_ram.
`default_nettype none

module sca_dpath #(
  parameter int CAPACITY   = sca_pkg::DEF_CAPACITY,
  parameter int INDEX_BITS = sca_pkg::DEF_INDEX_BITS,
  parameter int VALUE_BITS = sca_pkg::DEF_VALUE_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sca_pkg::sca_cmd_t                   cmd,
  output sca_pkg::sca_stat_t                       stat,
  input  wire logic [sca_pkg::MODE_W-1:0]          in_mode,
  input  wire logic [INDEX_BITS-1:0]               in_row_index,
  input  wire logic [INDEX_BITS-1:0]               in_col_index,
  input  wire logic signed [VALUE_BITS-1:0]        in_elem_value,
  input  wire logic                                in_overwrite_flag,
  input  wire logic                                cfg_we,
  input  wire logic [sca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic                                cfg_data,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic signed [VALUE_BITS-1:0]             out_read_value,
  output logic [sca_pkg::STATUS_W-1:0]             out_status,
  output logic [sca_pkg::COUNT_W-1:0]              out_entry_count
);

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = 2 * INDEX_BITS + VALUE_BITS;

  function automatic logic signed [VALUE_BITS-1:0] sat_add(
    input logic signed [VALUE_BITS-1:0] a,
    input logic signed [VALUE_BITS-1:0] b
  );
    logic [VALUE_BITS:0] s;
    s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
    if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
      sat_add = {s[VALUE_BITS], {(VALUE_BITS-1){~s[VALUE_BITS]}}};
    end else begin
      sat_add = s[VALUE_BITS-1:0];
    end
  endfunction

  // Config registers.
  logic allow_dup_r, allow_dup_nxt;
  logic ovr_app_r, ovr_app_nxt;
  logic one_based_r, one_based_nxt;

  // Item registers.
  sca_pkg::mode_t                 mode_r, mode_nxt;
  logic [INDEX_BITS-1:0]          row_r, row_nxt;
  logic [INDEX_BITS-1:0]          col_r, col_nxt;
  logic signed [VALUE_BITS-1:0]   val_r, val_nxt;
  logic                           ovr_r, ovr_nxt;
  logic                           bad_r, bad_nxt;

  // Scan and table state.
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [CNT_W-1:0]               ia_r, ia_nxt;
  logic [ADDR_W-1:0]              di_r, di_nxt;
  logic                           found_r, found_nxt;
  logic signed [VALUE_BITS-1:0]   acc_r, acc_nxt;
  sca_pkg::status_t               code_r, code_nxt;

  // Result register.
  logic                           out_valid_r, out_valid_nxt;
  logic signed [VALUE_BITS-1:0]   out_val_r, out_val_nxt;
  sca_pkg::status_t               out_st_r, out_st_nxt;
  logic [CNT_W-1:0]               out_cnt_r, out_cnt_nxt;

  // Entry store.
  logic                           ram_we, ram_re;
  logic [ADDR_W-1:0]              ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]             ram_wdata, ram_rdata;

  logic [INDEX_BITS-1:0]          rd_row, rd_col;
  logic signed [VALUE_BITS-1:0]   rd_val, upd_val;
  logic                           hit, last, issue, set_hit;

  sca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_row  = ram_rdata[ENTRY_W-1 -: INDEX_BITS];
  assign rd_col  = ram_rdata[VALUE_BITS +: INDEX_BITS];
  assign rd_val  = ram_rdata[VALUE_BITS-1:0];
  assign hit     = (rd_row == row_r) && (rd_col == col_r);
  assign last    = (CNT_W'(di_r) + CNT_W'(1)) == count_r;
  assign issue   = cmd.scan_step && (ia_r < count_r);
  assign set_hit = cmd.scan_step && hit && (mode_r == sca_pkg::MODE_SET);
  assign upd_val = ovr_r ? val_r : sat_add(rd_val, val_r);

  assign ram_re    = cmd.scan_start || issue;
  assign ram_raddr = cmd.scan_start ? '0 : ia_r[ADDR_W-1:0];
  assign ram_we    = set_hit || cmd.append;
  assign ram_waddr = cmd.append ? count_r[ADDR_W-1:0] : di_r;
  assign ram_wdata = cmd.append ? {row_r, col_r, val_r} : {rd_row, rd_col, upd_val};

  always_comb begin
    allow_dup_nxt = allow_dup_r;
    ovr_app_nxt   = ovr_app_r;
    one_based_nxt = one_based_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sca_pkg::CFG_ALLOW_DUP:   allow_dup_nxt = cfg_data;
        sca_pkg::CFG_OVR_APPENDS: ovr_app_nxt   = cfg_data;
        sca_pkg::CFG_ONE_BASED:   one_based_nxt = cfg_data;
        default:                  allow_dup_nxt = allow_dup_r;
      endcase
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    val_nxt   = val_r;
    ovr_nxt   = ovr_r;
    bad_nxt   = bad_r;
    found_nxt = found_r;
    acc_nxt   = acc_r;
    ia_nxt    = ia_r;
    di_nxt    = di_r;
    count_nxt = count_r;
    code_nxt  = code_r;

    if (cmd.load_item) begin
      // Take the item and move one-based indices to zero-based.
      mode_nxt  = sca_pkg::mode_t'(in_mode);
      row_nxt   = one_based_r ? in_row_index - INDEX_BITS'(1) : in_row_index;
      col_nxt   = one_based_r ? in_col_index - INDEX_BITS'(1) : in_col_index;
      val_nxt   = in_elem_value;
      ovr_nxt   = in_overwrite_flag;
      bad_nxt   = one_based_r && ((in_row_index == '0) || (in_col_index == '0));
      found_nxt = 1'b0;
      acc_nxt   = '0;
    end
    if (cmd.scan_start) begin
      ia_nxt = CNT_W'(1);
      di_nxt = '0;
    end
    if (cmd.scan_step) begin
      di_nxt = ia_r[ADDR_W-1:0];
      if (issue) begin
        ia_nxt = ia_r + CNT_W'(1);
      end
      if (hit && mode_r == sca_pkg::MODE_GET) begin
        acc_nxt = sat_add(acc_r, rd_val);
      end
    end
    if (set_hit) begin
      found_nxt = 1'b1;
      // Later duplicates see a zero incoming value.
      if (allow_dup_r) begin
        val_nxt = '0;
      end
    end
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.append) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.code_we) begin
      code_nxt = cmd.code;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = acc_r;
      out_st_nxt    = code_r;
      out_cnt_nxt   = count_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_dup_r <= 1'b0;
      ovr_app_r   <= 1'b0;
      one_based_r <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      allow_dup_r <= allow_dup_nxt;
      ovr_app_r   <= ovr_app_nxt;
      one_based_r <= one_based_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    val_r     <= val_nxt;
    ovr_r     <= ovr_nxt;
    bad_r     <= bad_nxt;
    found_r   <= found_nxt;
    acc_r     <= acc_nxt;
    ia_r      <= ia_nxt;
    di_r      <= di_nxt;
    code_r    <= code_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  always_comb begin
    stat.mode        = mode_r;
    stat.bad         = bad_r;
    stat.need_search = (ovr_r && !ovr_app_r) || (!ovr_r && !allow_dup_r);
    stat.empty       = (count_r == '0);
    stat.full        = (count_r >= CNT_W'(CAPACITY));
    stat.scan_done   = (hit && !allow_dup_r) || last;
    stat.found_any   = found_r || (hit && mode_r == sca_pkg::MODE_SET);
    stat.out_busy    = out_valid_r && !out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_val_r;
  assign out_status      = out_st_r;
  assign out_entry_count = sca_pkg::COUNT_W'(out_cnt_r);

endmodule

`default_nettype wire

// ===== sv/sparse_coo_assembly_table.sv =====
// Top level of the sparse COO assembly table: controller plus datapath.
// Depends on sca_pkg, sca_ctrl, sca_dpath and (through it) sca_ram.
//
// Usage
//   Input channel (in_*): one transaction carries a mode (set, get or
//   clear), a row and column index, a signed Q16.16 value and an
//   overwrite flag. Result channel (out_*): exactly one transaction per
//   input transaction, in order, with the read value, a status code and
//   the number of entries held afterwards. Configuration channel (cfg_*):
//   always ready; write only while the block is idle.
//   Timing: an item is decoded in the cycle after acceptance. A set or get
//   that searches reads one stored entry per cycle through the single read
//   port of the entry store; with duplicates off the search ends at the
//   first match, and a set that finds no match then appends if there is
//   room. A clear, a bad index, an unused mode or a get on an empty table
//   goes straight to the result, and a set may append without searching.
//   One item is worked at a time; the next is accepted in the first cycle
//   that the previous result sits in the output register, even if the
//   receiver has not yet taken it.
//   Reset: synchronous, active low; empties the table and clears the
//   policy registers. The store contents are not cleared, since only
//   entries below the fill count are ever read.
//   Stall: while out_ready is low the result holds, and a finished item
//   waits in its final state until the output register frees.
`default_nettype none

module sparse_coo_assembly_table #(
  parameter int CAPACITY   = sca_pkg::DEF_CAPACITY,
  parameter int INDEX_BITS = sca_pkg::DEF_INDEX_BITS,
  parameter int VALUE_BITS = sca_pkg::DEF_VALUE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input transactions
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sca_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [INDEX_BITS-1:0]         in_row_index,
  input  wire logic [INDEX_BITS-1:0]         in_col_index,
  input  wire logic signed [VALUE_BITS-1:0]  in_elem_value,
  input  wire logic                          in_overwrite_flag,
  // result transactions
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [VALUE_BITS-1:0]       out_read_value,
  output logic [sca_pkg::STATUS_W-1:0]       out_status,
  output logic [sca_pkg::COUNT_W-1:0]        out_entry_count,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                          cfg_data
);

  sca_pkg::sca_cmd_t  cmd;
  sca_pkg::sca_stat_t stat;

  // Register writes never need to wait, so never hold off the port.
  assign cfg_ready = 1'b1;

  // Sequence each item: decode, scan and append as needed, then hand over the result.
  sca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the table, the item under work and the result register.
  sca_dpath #(
    .CAPACITY   (CAPACITY),
    .INDEX_BITS (INDEX_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_mode),
    .in_row_index      (in_row_index),
    .in_col_index      (in_col_index),
    .in_elem_value     (in_elem_value),
    .in_overwrite_flag (in_overwrite_flag),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_read_value    (out_read_value),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count)
  );

endmodule

`default_nettype wire

// ===== tb/tb_sparse_coo_assembly_table.sv =====
// Self-checking testbench for the sparse COO assembly table.
// Holds its own copy of the table, predicts every result and compares it on the out_ channel.
// Depends on sca_pkg and sparse_coo_assembly_table only.
`timescale 1ns / 1ps

module tb_sparse_coo_assembly_table;

  localparam int CAP = sca_pkg::DEF_CAPACITY;
  localparam int IB  = sca_pkg::DEF_INDEX_BITS;
  localparam int VB  = sca_pkg::DEF_VALUE_BITS;

  // Mode code that the block leaves unused; it must report done and change nothing.
  localparam logic [sca_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic signed [VB-1:0] Q_MAX  = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] Q_MIN  = {1'b1, {(VB-1){1'b0}}};
  localparam logic signed [VB-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [VB-1:0] Q_HALF = 32'sh0000_8000;

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 64;
  localparam int FILL_ITEMS      = 36;
  localparam int LONG_GAP        = 40;

  // Bound every transaction by a full-table scan plus the longest gap on
  // each side, for generously more transactions than are sent, four times over.
  localparam longint TIMEOUT_NS = 64'd4 * 1700 * (CAP + 8 + 2 * LONG_GAP) * 10;

  typedef struct {
    logic [sca_pkg::MODE_W-1:0] mode;
    logic [IB-1:0]              row;
    logic [IB-1:0]              col;
    logic signed [VB-1:0]       value;
    logic                       ovr;
  } coo_item_t;

  typedef struct {
    logic signed [VB-1:0]        read_value;
    sca_pkg::status_t            status;
    logic [sca_pkg::COUNT_W-1:0] entry_count;
  } coo_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [sca_pkg::MODE_W-1:0]    in_mode = sca_pkg::MODE_SET;
  logic [IB-1:0]                 in_row_index = '0;
  logic [IB-1:0]                 in_col_index = '0;
  logic signed [VB-1:0]          in_elem_value = '0;
  logic                          in_overwrite_flag = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [VB-1:0]          out_read_value;
  logic [sca_pkg::STATUS_W-1:0]  out_status;
  logic [sca_pkg::COUNT_W-1:0]   out_entry_count;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [sca_pkg::CFG_IDX_W-1:0] cfg_index = sca_pkg::CFG_ALLOW_DUP;
  logic                          cfg_data = 1'b0;

  sparse_coo_assembly_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_row_index      (in_row_index),
    .in_col_index      (in_col_index),
    .in_elem_value     (in_elem_value),
    .in_overwrite_flag (in_overwrite_flag),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_value    (out_read_value),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow table: our own copy of the entries and policy bits.
  // ---------------------------------------------------------------------------
  logic [IB-1:0]        shadow_rows [CAP];
  logic [IB-1:0]        shadow_cols [CAP];
  logic signed [VB-1:0] shadow_vals [CAP];
  int                   shadow_used = 0;
  bit                   pol_dup = 1'b0;
  bit                   pol_ovr_appends = 1'b0;
  bit                   pol_one_based = 1'b0;

  coo_item_t   items_to_send [$];
  coo_result_t results_due [$];
  int          outstanding = 0;   // queued transactions whose result has not yet come
  int          mismatches = 0;
  bit          gaps_on = 1'b1;

  // Q16.16 addition clamped to the signed range.
  function automatic logic signed [VB-1:0] q_sat_add(input logic signed [VB-1:0] a,
                                                     input logic signed [VB-1:0] b);
    logic signed [VB:0] wide;
    wide = a + b;
    if (wide[VB] != wide[VB-1]) return wide[VB] ? Q_MIN : Q_MAX;
    return wide[VB-1:0];
  endfunction

  // Apply one transaction to the shadow table and return the result it must produce.
  function automatic coo_result_t apply_to_shadow_table(input coo_item_t it);
    coo_result_t          res;
    logic [IB-1:0]        row;
    logic [IB-1:0]        col;
    logic signed [VB-1:0] v;
    bit                   found;
    res.read_value = '0;
    res.status     = sca_pkg::ST_DONE;
    row   = it.row;
    col   = it.col;
    v     = it.value;
    found = 1'b0;
    if (it.mode == sca_pkg::MODE_CLEAR) begin
      shadow_used = 0;
    end else if (it.mode == sca_pkg::MODE_SET || it.mode == sca_pkg::MODE_GET) begin
      if (pol_one_based && (row == 0 || col == 0)) begin
        res.status = sca_pkg::ST_BAD_INDEX;
      end else begin
        if (pol_one_based) begin
          row = row - 1'b1;
          col = col - 1'b1;
        end
        if (it.mode == sca_pkg::MODE_GET) begin
          // Sum every match, or stop at the first when duplicates are off.
          for (int i = 0; i < shadow_used; i++) begin
            if (shadow_rows[i] == row && shadow_cols[i] == col) begin
              res.read_value = q_sat_add(res.read_value, shadow_vals[i]);
              if (!pol_dup) break;
            end
          end
        end else begin
          if ((it.ovr && !pol_ovr_appends) || (!it.ovr && !pol_dup)) begin
            for (int i = 0; i < shadow_used; i++) begin
              if (shadow_rows[i] == row && shadow_cols[i] == col) begin
                shadow_vals[i] = it.ovr ? v : q_sat_add(shadow_vals[i], v);
                found = 1'b1;
                if (!pol_dup) break;
                // later duplicates see a zero contribution
                v = '0;
              end
            end
          end
          if (found) begin
            res.status = sca_pkg::ST_UPDATED;
          end else if (shadow_used >= CAP) begin
            res.status = sca_pkg::ST_FULL;
          end else begin
            shadow_rows[shadow_used] = row;
            shadow_cols[shadow_used] = col;
            shadow_vals[shadow_used] = v;
            shadow_used++;
            res.status = sca_pkg::ST_APPENDED;
          end
        end
      end
    end
    res.entry_count = shadow_used[sca_pkg::COUNT_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Mostly short gaps, a few long; none at all while gaps are switched off.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, LONG_GAP);
  endfunction

  // A small pool of coordinates so that matches happen often, plus zero,
  // the top of the range and full random values.
  function automatic logic [IB-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return IB'($urandom_range(1, 4));
    if (r < 80) return '0;
    if (r < 85) return {{(IB-1){1'b1}}, 1'($urandom_range(0, 1))};
    return IB'($urandom);
  endfunction

  function automatic logic signed [VB-1:0] pick_value();
    int                   r;
    logic signed [VB-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = VB'($urandom_range(0, 32'h0003_FFFF));
      if ($urandom_range(0, 1)) v = -v;
    end else if (r < 65) begin
      // near the rails, so that sums saturate
      v = $urandom_range(0, 1) ? Q_MAX - VB'($urandom_range(0, 32'h0000_FFFF))
                               : Q_MIN + VB'($urandom_range(0, 32'h0000_FFFF));
    end else begin
      v = VB'($urandom);
    end
    return v;
  endfunction

  function automatic void queue_item(input logic [sca_pkg::MODE_W-1:0] mode,
                                     input logic [IB-1:0] row,
                                     input logic [IB-1:0] col,
                                     input logic signed [VB-1:0] value,
                                     input logic ovr);
    coo_item_t it;
    it.mode  = mode;
    it.row   = row;
    it.col   = col;
    it.value = value;
    it.ovr   = ovr;
    items_to_send.push_back(it);
    outstanding++;
  endfunction

  // Hold until every queued transaction has produced its result.
  task automatic wait_drained();
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input sca_pkg::cfg_idx_t idx, input logic bitval);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bitval;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Policy changes happen only once the block has gone idle.
  task automatic set_policy(input logic dup, input logic ovr_appends, input logic one_based);
    wait_drained();
    write_reg(sca_pkg::CFG_ALLOW_DUP, dup);
    write_reg(sca_pkg::CFG_OVR_APPENDS, ovr_appends);
    write_reg(sca_pkg::CFG_ONE_BASED, one_based);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feed the input channel from items_to_send, with random gaps.
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin : drive_items
    coo_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      // channel free: either idle or its transaction is taken at this edge
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        nxt = items_to_send.pop_front();
        in_mode           <= nxt.mode;
        in_row_index      <= nxt.row;
        in_col_index      <= nxt.col;
        in_elem_value     <= nxt.value;
        in_overwrite_flag <= nxt.ovr;
        in_valid          <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: track policy writes, predict on acceptance, check results and
  // drive receiver stalls.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin : observe_results
    coo_item_t   seen;
    coo_result_t due;
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        sca_pkg::CFG_ALLOW_DUP:   pol_dup = cfg_data;
        sca_pkg::CFG_OVR_APPENDS: pol_ovr_appends = cfg_data;
        sca_pkg::CFG_ONE_BASED:   pol_one_based = cfg_data;
        default: ;
      endcase
    end
    if (rst_n && in_valid && in_ready) begin
      seen.mode  = in_mode;
      seen.row   = in_row_index;
      seen.col   = in_col_index;
      seen.value = in_elem_value;
      seen.ovr   = in_overwrite_flag;
      results_due.push_back(apply_to_shadow_table(seen));
    end
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: read_value %0d status %0d entry_count %0d",
               out_read_value, out_status, out_entry_count);
        mismatches++;
      end else begin
        due = results_due.pop_front();
        outstanding--;
        if (out_read_value !== due.read_value) begin
          $error("read_value: expected %0d, got %0d", due.read_value, out_read_value);
          mismatches++;
        end
        if (out_status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, out_status);
          mismatches++;
        end
        if (out_entry_count !== due.entry_count) begin
          $error("entry_count: expected %0d, got %0d", due.entry_count, out_entry_count);
          mismatches++;
        end
      end
    end
    // receiver back-pressure
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: append, add, read back, both rails, empty read, unused mode, clear.
    set_policy(1'b0, 1'b0, 1'b0);
    queue_item(sca_pkg::MODE_SET, '0, '0, Q_ONE, 1'b0);
    queue_item(sca_pkg::MODE_SET, '0, '0, Q_HALF, 1'b0);
    queue_item(sca_pkg::MODE_GET, '0, '0, '0, 1'b0);
    queue_item(sca_pkg::MODE_SET, '1, '1, Q_MAX, 1'b1);
    queue_item(sca_pkg::MODE_SET, '1, '1, Q_MAX, 1'b0);
    queue_item(sca_pkg::MODE_GET, '1, '1, '0, 1'b0);
    queue_item(sca_pkg::MODE_SET, '1, '1, Q_MIN, 1'b1);
    queue_item(sca_pkg::MODE_SET, '1, '1, Q_MIN, 1'b0);
    queue_item(sca_pkg::MODE_GET, '1, '1, '1, 1'b1);
    queue_item(sca_pkg::MODE_GET, 16'h0001, 16'h0002, '0, 1'b0);
    queue_item(MODE_UNUSED, 16'h0001, 16'h0001, Q_ONE, 1'b1);
    queue_item(sca_pkg::MODE_CLEAR, '0, '0, '0, 1'b0);
    queue_item(sca_pkg::MODE_GET, '0, '0, '0, 1'b0);

    // One-based input: zero coordinates are rejected, others shift down by one.
    set_policy(1'b0, 1'b0, 1'b1);
    queue_item(sca_pkg::MODE_SET, '0, 16'h0005, Q_ONE, 1'b0);
    queue_item(sca_pkg::MODE_GET, 16'h0003, '0, '0, 1'b0);
    queue_item(sca_pkg::MODE_SET, 16'h0001, 16'h0001, Q_HALF, 1'b0);
    // Back to zero-based: the stored entry keeps its coordinate.
    set_policy(1'b0, 1'b0, 1'b0);
    queue_item(sca_pkg::MODE_GET, '0, '0, '0, 1'b0);

    // Duplicates on, overwrite appends: every set lands in a new entry.
    set_policy(1'b1, 1'b1, 1'b0);
    queue_item(sca_pkg::MODE_SET, 16'h0002, 16'h0002, Q_ONE, 1'b1);
    queue_item(sca_pkg::MODE_SET, 16'h0002, 16'h0002, Q_HALF, 1'b1);
    queue_item(sca_pkg::MODE_SET, 16'h0002, 16'h0002, Q_ONE, 1'b0);
    queue_item(sca_pkg::MODE_GET, 16'h0002, 16'h0002, '0, 1'b0);
    // Overwrite with search: first match takes the value, later ones are zeroed.
    set_policy(1'b1, 1'b0, 1'b0);
    queue_item(sca_pkg::MODE_SET, 16'h0002, 16'h0002, -Q_ONE, 1'b1);
    queue_item(sca_pkg::MODE_GET, 16'h0002, 16'h0002, '0, 1'b0);

    // Load a batch of searchless appends so that later scans run long.
    set_policy(1'b1, 1'b1, 1'b0);
    queue_item(sca_pkg::MODE_CLEAR, '0, '0, '0, 1'b0);
    for (int k = 0; k < FILL_ITEMS; k++) begin
      queue_item(sca_pkg::MODE_SET, k == 0 ? 16'h1234 : IB'($urandom),
                 k == 0 ? 16'h5678 : IB'($urandom), VB'($urandom), 1'b1);
    end
    queue_item(sca_pkg::MODE_SET, 16'h0042, 16'h0042, Q_ONE, 1'b1);
    queue_item(sca_pkg::MODE_SET, 16'h0042, 16'h0042, Q_ONE, 1'b0);
    queue_item(sca_pkg::MODE_GET, 16'h1234, 16'h5678, '0, 1'b0);
    set_policy(1'b0, 1'b1, 1'b0);
    queue_item(sca_pkg::MODE_SET, 16'h1234, 16'h5678, Q_ONE, 1'b0);
    queue_item(sca_pkg::MODE_SET, '0, '1, Q_ONE, 1'b0);
    queue_item(sca_pkg::MODE_GET, 16'h1234, 16'h5678, '0, 1'b0);
    set_policy(1'b0, 1'b0, 1'b0);
    queue_item(sca_pkg::MODE_SET, 16'h00FF, 16'h0F0F, Q_HALF, 1'b1);
    queue_item(sca_pkg::MODE_CLEAR, '1, '1, '1, 1'b1);

    // Random phases, one per policy combination; the table carries over
    // between phases so that base changes meet stored entries.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_policy(p[0], p[1], p[2]);
      gaps_on = (p != 3);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // hold the sender once until every result is back
        if (p == 5 && k == ITEMS_PER_PHASE / 2) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
          queue_item(sca_pkg::MODE_SET, pick_index(), pick_index(), pick_value(),
                     1'($urandom_range(0, 1)));
        end else if (pick < 92) begin
          queue_item(sca_pkg::MODE_GET, pick_index(), pick_index(), VB'($urandom),
                     1'($urandom_range(0, 1)));
        end else begin
          queue_item(sca_pkg::MODE_CLEAR, IB'($urandom), IB'($urandom), VB'($urandom),
                     1'($urandom_range(0, 1)));
        end
      end
    end

    wait_drained();
    // allow a stray late result to show up before the verdict
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
